// ----- rtl/swms_pkg.sv -----
// Shared types and constants for the stop-and-wait MAC sequencer.
// Holds opcode, result and register codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package swms_pkg;

   localparam int ADDR_W  = 8;
   localparam int SEQ_W   = 8;
   localparam int ENTRY_W = ADDR_W + SEQ_W;

   // opcodes
   localparam logic [1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [1:0] OP_RX_FRAME = 2'd1;
   localparam logic [1:0] OP_OUTCOME  = 2'd2;

   // attempt results
   localparam logic [1:0] RES_DELIVERED = 2'd0;
   localparam logic [1:0] RES_RETRY     = 2'd1;
   localparam logic [1:0] RES_DROPPED   = 2'd2;
   localparam logic [1:0] RES_NONE      = 2'd3;

   // frame type bytes
   localparam logic [7:0] FRAME_ACK  = 8'h40;
   localparam logic [7:0] FRAME_DATA = 8'h80;

   // configuration registers
   localparam int         CSR_INDEX_W      = 2;
   localparam int         CSR_DATA_W       = 16;
   localparam logic [1:0] CSR_RETRY_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_BACKOFF_BASE = 2'd1;

   localparam logic [3:0]  RETRY_LIMIT_RESET  = 4'd3;
   localparam logic [15:0] BACKOFF_BASE_RESET = 16'd16;

   typedef struct packed {
      logic capture;
      logic next_idx;
      logic set_hit;
      logic finish;
   } swms_cmd_type;

   typedef struct packed {
      logic table_op;
      logic at_end;
      logic match;
   } swms_status_type;

endpackage

`default_nettype wire

// ----- rtl/swms_ctrl.sv -----
// Controller for the MAC sequencer: walks a peer table one entry at a time.
// Depends on swms_pkg for the command and status structs.
`default_nettype none

module swms_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   output logic                           rsp_valid,
   input  wire swms_pkg::swms_status_type status,
   output swms_pkg::swms_cmd_type         cmd
);
   import swms_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_MATCH = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // skip the table when the item needs none or the filled part is exhausted
            if (!status.table_op || status.at_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (status.match) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.next_idx = 1'b1;
               state_in     = ST_LOOK;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign valid_in = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ----- rtl/swms_dpath.sv -----
// Datapath for the MAC sequencer: peer tables, retry counter, backoff and result registers.
// Depends on swms_pkg; driven by swms_ctrl through command and status structs.
`default_nettype none

module swms_dpath #(
   parameter int PEER_ENTRIES = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire swms_pkg::swms_cmd_type    cmd,
   output swms_pkg::swms_status_type      status,
   input  wire logic [1:0]                req_opcode,
   input  wire logic [7:0]                req_peer_address,
   input  wire logic [7:0]                req_frame_type,
   input  wire logic [7:0]                req_frame_seq,
   input  wire logic                      req_attempt_ok,
   input  wire logic [7:0]                req_reply_type,
   input  wire logic [15:0]               req_random_value,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [swms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [swms_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [7:0]                     rsp_tx_sequence,
   output logic                           rsp_deliver,
   output logic                           rsp_send_ack,
   output logic [1:0]                     rsp_attempt_result,
   output logic [15:0]                    rsp_backoff_ticks,
   output logic [3:0]                     rsp_retry_count,
   output logic                           rsp_table_full
);
   import swms_pkg::*;

   localparam int IDX_W = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
   localparam int CNT_W = $clog2(PEER_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PEER_ENTRIES);

   // captured transaction
   logic [1:0]  opcode_ff;
   logic [7:0]  peer_ff, ftype_ff, fseq_ff, rtype_ff;
   logic        ok_ff;
   logic [15:0] rnd_ff;

   // configuration
   logic [3:0]  limit_ff;
   logic [15:0] base_ff;

   // control state
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] tx_cnt_ff, tx_cnt_in, rx_cnt_ff, rx_cnt_in;
   logic             hit_ff;
   logic [3:0]       retries_ff, retries_in;

   // tables
   logic [ENTRY_W-1:0] tx_mem [PEER_ENTRIES];
   logic [ENTRY_W-1:0] rx_mem [PEER_ENTRIES];
   logic [ENTRY_W-1:0] tx_rd_ff, rx_rd_ff;

   // result registers
   logic [7:0]  txseq_ff, txseq_in;
   logic        deliver_ff, deliver_in;
   logic        ack_ff, ack_in;
   logic [1:0]  result_ff, result_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        full_ff, full_in;

   logic               use_tx;
   logic [CNT_W-1:0]   cnt_sel;
   logic               sel_full;
   logic [ADDR_W-1:0]  rd_addr;
   logic [SEQ_W-1:0]   rd_seq;
   logic               tx_we, rx_we;
   logic [IDX_W-1:0]   wr_idx;
   logic [ENTRY_W-1:0] wr_entry;
   logic [15:0]        window, mask;

   assign use_tx   = (opcode_ff == OP_ENQUEUE);
   assign cnt_sel  = use_tx ? tx_cnt_ff : rx_cnt_ff;
   assign sel_full = (cnt_sel == CNT_FULL);
   assign rd_addr  = use_tx ? tx_rd_ff[ENTRY_W-1:SEQ_W] : rx_rd_ff[ENTRY_W-1:SEQ_W];
   assign rd_seq   = use_tx ? tx_rd_ff[SEQ_W-1:0] : rx_rd_ff[SEQ_W-1:0];
   assign wr_idx   = hit_ff ? idx_ff[IDX_W-1:0] : cnt_sel[IDX_W-1:0];

   assign status.table_op = (peer_ff != '0) &&
                            ((opcode_ff == OP_ENQUEUE) ||
                             (opcode_ff == OP_RX_FRAME && ftype_ff == FRAME_DATA));
   assign status.at_end   = (idx_ff == cnt_sel);
   assign status.match    = (rd_addr == peer_ff);

   // window wraps to zero past 16 bits, which opens the mask fully
   assign window = base_ff << retries_ff;
   assign mask   = window - 16'd1;

   always_comb begin
      txseq_in   = '0;
      deliver_in = 1'b0;
      ack_in     = 1'b0;
      result_in  = RES_NONE;
      ticks_in   = '0;
      full_in    = 1'b0;
      tx_we      = 1'b0;
      rx_we      = 1'b0;
      wr_entry   = '0;
      retries_in = retries_ff;
      tx_cnt_in  = tx_cnt_ff;
      rx_cnt_in  = rx_cnt_ff;
      case (opcode_ff)
         OP_ENQUEUE: begin
            if (peer_ff != '0) begin
               if (hit_ff) begin
                  txseq_in = rd_seq;
                  tx_we    = 1'b1;
                  wr_entry = {peer_ff, SEQ_W'(rd_seq + 8'd1)};
               end else if (!sel_full) begin
                  tx_we     = 1'b1;
                  wr_entry  = {peer_ff, 8'd1};
                  tx_cnt_in = CNT_W'(tx_cnt_ff + 1'b1);
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         OP_RX_FRAME: begin
            if (ftype_ff == FRAME_DATA) begin
               ack_in     = 1'b1;
               deliver_in = 1'b1;
               if (peer_ff != '0) begin
                  if (hit_ff) begin
                     // drop a repeat of the last accepted sequence
                     if (rd_seq == fseq_ff) begin
                        deliver_in = 1'b0;
                     end else begin
                        rx_we    = 1'b1;
                        wr_entry = {peer_ff, fseq_ff};
                     end
                  end else if (!sel_full) begin
                     rx_we     = 1'b1;
                     wr_entry  = {peer_ff, fseq_ff};
                     rx_cnt_in = CNT_W'(rx_cnt_ff + 1'b1);
                  end else begin
                     full_in = 1'b1;
                  end
               end
            end
         end
         OP_OUTCOME: begin
            if (ok_ff && rtype_ff == FRAME_ACK) begin
               retries_in = '0;
               result_in  = RES_DELIVERED;
            end else if (retries_ff >= limit_ff) begin
               retries_in = '0;
               result_in  = RES_DROPPED;
            end else begin
               ticks_in   = rnd_ff & mask;
               retries_in = 4'(retries_ff + 4'd1);
               result_in  = RES_RETRY;
            end
         end
         default: begin
         end
      endcase
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req_opcode;
         peer_ff   <= req_peer_address;
         ftype_ff  <= req_frame_type;
         fseq_ff   <= req_frame_seq;
         ok_ff     <= req_attempt_ok;
         rtype_ff  <= req_reply_type;
         rnd_ff    <= req_random_value;
      end
   end

   // configuration registers; writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_LIMIT_RESET;
         base_ff  <= BACKOFF_BASE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RETRY_LIMIT:  limit_ff <= csr_data[3:0];
            CSR_BACKOFF_BASE: base_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // scan index, fill counts, retry counter
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         hit_ff     <= 1'b0;
         tx_cnt_ff  <= '0;
         rx_cnt_ff  <= '0;
         retries_ff <= '0;
      end else begin
         if (cmd.capture) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end else begin
            if (cmd.next_idx) begin
               idx_ff <= CNT_W'(idx_ff + 1'b1);
            end
            if (cmd.set_hit) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            tx_cnt_ff  <= tx_cnt_in;
            rx_cnt_ff  <= rx_cnt_in;
            retries_ff <= retries_in;
         end
      end
   end

   // peer tables; entries past the fill count are never read for a decision
   always_ff @(posedge clock) begin
      if (cmd.finish && tx_we) begin
         tx_mem[wr_idx] <= wr_entry;
      end
      tx_rd_ff <= tx_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && rx_we) begin
         rx_mem[wr_idx] <= wr_entry;
      end
      rx_rd_ff <= rx_mem[idx_ff[IDX_W-1:0]];
   end

   // hold results for the strobe cycle
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         txseq_ff   <= txseq_in;
         deliver_ff <= deliver_in;
         ack_ff     <= ack_in;
         result_ff  <= result_in;
         ticks_ff   <= ticks_in;
         full_ff    <= full_in;
      end
   end

   assign rsp_tx_sequence    = txseq_ff;
   assign rsp_deliver        = deliver_ff;
   assign rsp_send_ack       = ack_ff;
   assign rsp_attempt_result = result_ff;
   assign rsp_backoff_ticks  = ticks_ff;
   assign rsp_retry_count    = retries_ff;
   assign rsp_table_full     = full_ff;

endmodule

`default_nettype wire

// ----- rtl/stop_and_wait_mac_sequencer_top.sv -----
// Stop-and-wait MAC sequencer: per-peer sequence tables, retry counter, backoff.
// Sequence: after accept the controller checks in LOOK whether a table walk is needed; each
// entry visited takes the LOOK, FETCH and MATCH states, FETCH covering the registered table read.
// The walk ends in DONE, and the result strobe comes from a register set in DONE. A new
// transaction is taken only in IDLE, once the last one is through. Results cannot be stalled.
// Reset (synchronous): tables empty, retry counter zero, retry_limit 3, backoff_base 16.
`default_nettype none

module stop_and_wait_mac_sequencer_top #(
   parameter int PEER_ENTRIES = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [7:0]                       req_peer_address,
   input  wire logic [7:0]                       req_frame_type,
   input  wire logic [7:0]                       req_frame_seq,
   input  wire logic                             req_attempt_ok,
   input  wire logic [7:0]                       req_reply_type,
   input  wire logic [15:0]                      req_random_value,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [swms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [swms_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_tx_sequence,
   output logic                                  rsp_deliver,
   output logic                                  rsp_send_ack,
   output logic [1:0]                            rsp_attempt_result,
   output logic [15:0]                           rsp_backoff_ticks,
   output logic [3:0]                            rsp_retry_count,
   output logic                                  rsp_table_full
);
   import swms_pkg::*;

   swms_cmd_type    cmd;
   swms_status_type status;

   swms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   swms_dpath #(
      .PEER_ENTRIES (PEER_ENTRIES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_peer_address   (req_peer_address),
      .req_frame_type     (req_frame_type),
      .req_frame_seq      (req_frame_seq),
      .req_attempt_ok     (req_attempt_ok),
      .req_reply_type     (req_reply_type),
      .req_random_value   (req_random_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_tx_sequence    (rsp_tx_sequence),
      .rsp_deliver        (rsp_deliver),
      .rsp_send_ack       (rsp_send_ack),
      .rsp_attempt_result (rsp_attempt_result),
      .rsp_backoff_ticks  (rsp_backoff_ticks),
      .rsp_retry_count    (rsp_retry_count),
      .rsp_table_full     (rsp_table_full)
   );

endmodule

`default_nettype wire

// ----- rtl/swms_checker.sv -----
// Port-level checks for the MAC sequencer, bound to the top level.
// Depends on swms_pkg for result codes.
`default_nettype none

module swms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [7:0]  rsp_tx_sequence,
   input wire logic [1:0]  rsp_attempt_result,
   input wire logic [15:0] rsp_backoff_ticks
);
   import swms_pkg::*;

   // an accepted transaction occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // the end of every transaction produces exactly one strobe
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("transaction finished without a result strobe");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_ticks_retry_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attempt_result != RES_RETRY |-> rsp_backoff_ticks == 16'd0)
      else $error("backoff ticks on a non-retry result");

   a_seq_enqueue_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_sequence != 8'd0 |-> rsp_attempt_result == RES_NONE)
      else $error("transmit sequence on an outcome result");

endmodule

bind stop_and_wait_mac_sequencer_top swms_checker u_swms_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_tx_sequence    (rsp_tx_sequence),
   .rsp_attempt_result (rsp_attempt_result),
   .rsp_backoff_ticks  (rsp_backoff_ticks)
);

`default_nettype wire
